// ===== rtl/jmsp_pkg.sv =====
// ----------------------------------------------------------------------------
// JPEG marker segment parser - shared definitions
// Codes, result record layout and small helper functions.
// ----------------------------------------------------------------------------
package jmsp_pkg;

   localparam int SECTION_LIMIT_DEF = 20;
   localparam int MAX_PADDING_DEF   = 6;

   localparam int RSP_DEPTH    = 8;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W    = $clog2(RSP_DEPTH + 1) + 1;
   localparam int RSP_DATA_W   = 72;
   localparam int SECT_W       = 6;
   localparam int PAD_W        = 3;

   // request commands
   localparam logic [1:0] CMD_DATA    = 2'd0;
   localparam logic [1:0] CMD_END     = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // result events
   localparam logic [2:0] EV_HEADER = 3'd0;
   localparam logic [2:0] EV_FRAME  = 3'd1;
   localparam logic [2:0] EV_EXIF   = 3'd2;
   localparam logic [2:0] EV_DONE   = 3'd3;
   localparam logic [2:0] EV_ERROR  = 3'd4;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BAD_START = 3'd0;
   localparam logic [2:0] ERR_PADDING   = 3'd1;
   localparam logic [2:0] ERR_BAD_LEN   = 3'd2;
   localparam logic [2:0] ERR_TRUNC     = 3'd3;
   localparam logic [2:0] ERR_EOI       = 3'd4;

   // marker bytes
   localparam logic [7:0] BYTE_FF  = 8'hFF;
   localparam logic [7:0] M_SOI    = 8'hD8;
   localparam logic [7:0] M_EOI    = 8'hD9;
   localparam logic [7:0] M_SOS    = 8'hDA;
   localparam logic [7:0] M_APP0   = 8'hE0;
   localparam logic [7:0] M_APP1   = 8'hE1;

   localparam logic [15:0] LEN_MIN      = 16'd2;
   localparam logic [15:0] LEN_SOF_MIN  = 16'd8;
   localparam logic [15:0] LEN_EXIF_MIN = 16'd6;
   localparam logic [7:0]  COLOUR_COMPS = 8'd3;

   typedef enum logic [6:0] {
      PH_START_FF = 7'b0000001,
      PH_START_D8 = 7'b0000010,
      PH_MARKER   = 7'b0000100,
      PH_LEN_HI   = 7'b0001000,
      PH_LEN_LO   = 7'b0010000,
      PH_PAYLOAD  = 7'b0100000,
      PH_DONE     = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  marker_code;
      logic [15:0] segment_length;
      logic [7:0]  sample_precision;
      logic [15:0] image_height;
      logic [15:0] image_width;
      logic        is_color;
      logic [2:0]  error_code;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item1;
      rsp_item_type item0;
   } rsp_push_type;

   function automatic logic is_sof(input logic [7:0] m);
      logic r;
      r = 1'b0;
      if (m[7:4] == 4'hC) begin
         r = (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
      end
      return r;
   endfunction

   function automatic logic [7:0] exif_char(input logic [1:0] i);
      logic [7:0] c;
      case (i)
         2'd0:    c = 8'h45;
         2'd1:    c = 8'h78;
         2'd2:    c = 8'h69;
         default: c = 8'h66;
      endcase
      return c;
   endfunction

   function automatic rsp_item_type mk_item(input logic [2:0] ev, input logic [2:0] err,
                                            input logic [7:0] marker,
                                            input logic [15:0] len,
                                            input logic [47:0] frame);
      rsp_item_type r;
      r = '0;
      r.event_res      = ev;
      r.marker_code    = marker;
      r.segment_length = len;
      r.error_code     = err;
      if (ev == EV_FRAME) begin
         r.sample_precision = frame[47:40];
         r.image_height     = frame[39:24];
         r.image_width      = frame[23:8];
         r.is_color         = (frame[7:0] == COLOUR_COMPS);
      end
      return r;
   endfunction

endpackage

// ===== rtl/jmsp_parser.sv =====
// ----------------------------------------------------------------------------
// JPEG marker segment parser - byte parser
// Registers one request, then updates the parse state and forms up to two
// results for it in a single pass.
// ----------------------------------------------------------------------------
module jmsp_parser
   import jmsp_pkg::*;
#(
   parameter int SECTION_LIMIT = SECTION_LIMIT_DEF,
   parameter int MAX_PADDING   = MAX_PADDING_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_take,
   input  logic [1:0]   in_cmd,
   input  logic [7:0]   in_byte,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   output logic         stage_busy,
   output rsp_push_type push
);

   localparam logic [SECT_W-1:0] SC_LAST = SECT_W'(SECTION_LIMIT - 1);
   localparam logic [PAD_W-1:0]  PAD_MAX = PAD_W'(MAX_PADDING);

   logic              stage_valid_ff;
   logic [1:0]        stage_cmd_ff;
   logic [7:0]        stage_byte_ff;
   logic              exif_en_ff;

   phase_type         phase_ff, phase_in;
   logic [PAD_W-1:0]  pad_ff, pad_in;
   logic [7:0]        marker_ff, marker_in;
   logic [15:0]       len_ff, len_in;
   logic [15:0]       idx_ff, idx_in;
   logic [SECT_W-1:0] sc_ff, sc_in;
   logic [47:0]       frame_ff, frame_in;
   logic              match_ff, match_in;

   logic              finish;
   logic              counted;
   logic [SECT_W-1:0] sc_new;
   logic [1:0]        n;
   rsp_item_type      res [2];

   assign stage_busy = stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         exif_en_ff     <= 1'b1;
         phase_ff       <= PH_START_FF;
         pad_ff         <= '0;
         marker_ff      <= '0;
         len_ff         <= '0;
         idx_ff         <= '0;
         sc_ff          <= '0;
         frame_ff       <= '0;
         match_ff       <= 1'b1;
      end else begin
         stage_valid_ff <= in_take;
         if (csr_wr_en) begin
            exif_en_ff <= csr_wr_data;
         end
         phase_ff  <= phase_in;
         pad_ff    <= pad_in;
         marker_ff <= marker_in;
         len_ff    <= len_in;
         idx_ff    <= idx_in;
         sc_ff     <= sc_in;
         frame_ff  <= frame_in;
         match_ff  <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         stage_cmd_ff  <= in_cmd;
         stage_byte_ff <= in_byte;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      pad_in    = pad_ff;
      marker_in = marker_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      sc_in     = sc_ff;
      frame_in  = frame_ff;
      match_in  = match_ff;
      finish    = 1'b0;
      counted   = 1'b1;
      sc_new    = sc_ff;
      n         = 2'd0;
      res[0]    = '0;
      res[1]    = '0;

      if (stage_valid_ff) begin
         case (stage_cmd_ff)
            CMD_DATA: begin
               case (phase_ff)
                  PH_START_FF: begin
                     if (stage_byte_ff != BYTE_FF) begin
                        phase_in = PH_DONE;
                        res[0] = mk_item(EV_ERROR, ERR_BAD_START, marker_ff, len_ff, frame_ff);
                        n = 2'd1;
                     end else begin
                        phase_in = PH_START_D8;
                     end
                  end
                  PH_START_D8: begin
                     if (stage_byte_ff != M_SOI) begin
                        phase_in = PH_DONE;
                        res[0] = mk_item(EV_ERROR, ERR_BAD_START, marker_ff, len_ff, frame_ff);
                        n = 2'd1;
                     end else if (sc_ff >= SC_LAST) begin
                        phase_in = PH_DONE;
                        res[0] = mk_item(EV_DONE, ERR_NONE, marker_ff, len_ff, frame_ff);
                        n = 2'd1;
                     end else begin
                        phase_in = PH_MARKER;
                        pad_in   = '0;
                     end
                  end
                  PH_MARKER: begin
                     if (stage_byte_ff == BYTE_FF) begin
                        if (pad_ff >= PAD_MAX) begin
                           phase_in = PH_DONE;
                           res[0] = mk_item(EV_ERROR, ERR_PADDING, marker_ff, len_ff, frame_ff);
                           n = 2'd1;
                        end else begin
                           pad_in = pad_ff + PAD_W'(1);
                        end
                     end else begin
                        marker_in = stage_byte_ff;
                        phase_in  = PH_LEN_HI;
                     end
                  end
                  PH_LEN_HI: begin
                     len_in   = {stage_byte_ff, 8'h00};
                     phase_in = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     len_in = {len_ff[15:8], stage_byte_ff};
                     if (len_in < LEN_MIN) begin
                        phase_in = PH_DONE;
                        res[0] = mk_item(EV_ERROR, ERR_BAD_LEN, marker_ff, len_in, frame_ff);
                        n = 2'd1;
                     end else begin
                        res[0] = mk_item(EV_HEADER, ERR_NONE, marker_ff, len_in, frame_ff);
                        n        = 2'd1;
                        idx_in   = '0;
                        match_in = 1'b1;
                        frame_in = '0;
                        if (len_in == LEN_MIN) begin
                           finish = 1'b1;
                        end else begin
                           phase_in = PH_PAYLOAD;
                        end
                     end
                  end
                  PH_PAYLOAD: begin
                     for (int k = 0; k < 6; k++) begin
                        if (idx_ff == 16'(k)) begin
                           frame_in[8*(5-k) +: 8] = stage_byte_ff;
                        end
                     end
                     if (idx_ff < 16'd4 && stage_byte_ff != exif_char(idx_ff[1:0])) begin
                        match_in = 1'b0;
                     end
                     idx_in = idx_ff + 16'd1;
                     if (idx_in >= len_ff - LEN_MIN) begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CMD_END: begin
               if (phase_ff == PH_START_FF || phase_ff == PH_START_D8) begin
                  phase_in = PH_DONE;
                  res[0] = mk_item(EV_ERROR, ERR_BAD_START, marker_ff, len_ff, frame_ff);
                  n = 2'd1;
               end else if (phase_ff != PH_DONE) begin
                  phase_in = PH_DONE;
                  res[0] = mk_item(EV_ERROR, ERR_TRUNC, marker_ff, len_ff, frame_ff);
                  n = 2'd1;
               end
            end
            CMD_RESTART: begin
               phase_in  = PH_START_FF;
               pad_in    = '0;
               marker_in = '0;
               len_in    = '0;
               idx_in    = '0;
               sc_in     = '0;
               frame_in  = '0;
               match_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // end of segment
      if (finish) begin
         if (marker_in == M_SOS) begin
            sc_in    = sc_ff + SECT_W'(1);
            phase_in = PH_DONE;
            res[n[0]] = mk_item(EV_DONE, ERR_NONE, marker_in, len_in, frame_in);
            n = n + 2'd1;
         end else if (marker_in == M_EOI) begin
            phase_in = PH_DONE;
            res[n[0]] = mk_item(EV_ERROR, ERR_EOI, marker_in, len_in, frame_in);
            n = n + 2'd1;
         end else begin
            if (is_sof(marker_in)) begin
               if (len_in >= LEN_SOF_MIN) begin
                  res[n[0]] = mk_item(EV_FRAME, ERR_NONE, marker_in, len_in, frame_in);
                  n = n + 2'd1;
               end
            end else if (marker_in == M_APP0) begin
               counted = 1'b0;
            end else if (marker_in == M_APP1) begin
               if (exif_en_ff && match_in && len_in >= LEN_EXIF_MIN) begin
                  res[n[0]] = mk_item(EV_EXIF, ERR_NONE, marker_in, len_in, frame_in);
                  n = n + 2'd1;
               end else begin
                  counted = 1'b0;
               end
            end
            sc_new = counted ? sc_ff + SECT_W'(1) : sc_ff;
            sc_in  = sc_new;
            if (sc_new >= SC_LAST) begin
               phase_in = PH_DONE;
               res[n[0]] = mk_item(EV_DONE, ERR_NONE, marker_in, len_in, frame_in);
               n = n + 2'd1;
            end else begin
               phase_in = PH_MARKER;
               pad_in   = '0;
            end
         end
      end

      if (n == 2'd2) begin
         res[1].last_of_run = 1'b1;
      end else if (n == 2'd1) begin
         res[0].last_of_run = 1'b1;
      end
   end

   assign push.count = n;
   assign push.item0 = res[0];
   assign push.item1 = res[1];

endmodule

// ===== rtl/jmsp_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// JPEG marker segment parser - response queue
// Takes up to two results a cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
module jmsp_rsp_fifo
   import jmsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   input  logic         reserve,
   output logic         space_ok,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   rsp_item_type         mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   logic [RSP_CNT_W-1:0] need;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];

   // room for the staged request plus the next one, two results each
   assign need     = count_ff + (reserve ? RSP_CNT_W'(2) : RSP_CNT_W'(0));
   assign space_ok = (need <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push.count) - (pop ? RSP_CNT_W'(1) : RSP_CNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.item1;
      end
   end

endmodule

// ===== rtl/jpeg_marker_segment_parser_top.sv =====
// ----------------------------------------------------------------------------
// JPEG marker segment parser - top level
// Checks the start of image, walks the marker segments and reports headers,
// frame information, Exif segments, completion and errors.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_*: one request per file byte (tuser = command,
//   tdata = byte). Commands: data byte, end of stream, restart parse.
//   Response channel rsp_*: zero, one or two results per request, in order;
//   tlast marks the final result of a request.
//   csr_wr_en / csr_wr_data write the Exif enable bit; write only while idle.
// Timing:
//   A request accepted at one edge is held in the input register; its results
//   reach the response queue at the next edge and are shown from there. One
//   request per cycle is taken while the 8-entry response queue holds room
//   for two results of the staged request and two of the next.
// Reset: synchronous; clears the parse state and the queue, sets Exif enable.
// Stall: results wait in the queue; req_tready falls when it nears full and
//   no result is dropped.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_parser_top
   import jmsp_pkg::*;
#(
   parameter int SECTION_LIMIT = SECTION_LIMIT_DEF,
   parameter int MAX_PADDING   = MAX_PADDING_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // data_byte
   input  logic [1:0]            req_tuser,   // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // marker_code, segment_length, sample_precision, image_height,
   // image_width, is_color, error_code, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]            rsp_tuser,   // event_res
   output logic                  rsp_tlast,   // last_of_run
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   rsp_push_type push;
   rsp_item_type head;
   logic         stage_busy;
   logic         space_ok;
   logic         take;

   assign req_tready = space_ok;
   assign take       = req_tvalid && req_tready;

   jmsp_parser #(
      .SECTION_LIMIT (SECTION_LIMIT),
      .MAX_PADDING   (MAX_PADDING)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_take     (take),
      .in_cmd      (req_tuser),
      .in_byte     (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stage_busy  (stage_busy),
      .push        (push)
   );

   jmsp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .reserve   (stage_busy),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tuser = head.event_res;
   assign rsp_tlast = head.last_of_run;
   assign rsp_tdata = {4'b0000, head.error_code, head.is_color, head.image_width,
                       head.image_height, head.sample_precision, head.segment_length,
                       head.marker_code};

endmodule

// ===== rtl/jmsp_checker.sv =====
// ----------------------------------------------------------------------------
// JPEG marker segment parser - port checker
// Watches the response channel of the top level over time.
// ----------------------------------------------------------------------------
module jmsp_checker
   import jmsp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]            rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response shown after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= EV_ERROR)
      else $error("bad event code");

   a_err_only_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_ERROR |-> rsp_tdata[67:65] == 3'd0)
      else $error("error code on non-error response");

   a_frame_only_on_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_FRAME |-> rsp_tdata[64:24] == '0)
      else $error("frame fields on non-frame response");

endmodule

bind jpeg_marker_segment_parser_top jmsp_checker u_jmsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/tb_jpeg_marker_segment_parser_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JPEG marker segment parser - testbench
// Drives byte requests through the request stream and checks every result
// against a local model of the parser, or against its own row for a typed
// directed request. A short table of directed requests comes first, then
// generated JPEG-like streams with random content, broken headers and noise,
// under both Exif enable settings and with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_jpeg_marker_segment_parser_top
   import jmsp_pkg::*;
();

   localparam int SECTION_LIMIT  = SECTION_LIMIT_DEF;
   localparam int MAX_PADDING    = MAX_PADDING_DEF;
   localparam int RESET_CYCLES   = 9;
   localparam int DRAIN_CYCLES   = 6;
   localparam int RANDOM_ITEMS   = 300;
   localparam int RANDOM_PHASES  = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [7:0] M_SOF0 = 8'hC0;
   localparam logic [7:0] M_DHT  = 8'hC4;
   localparam logic [7:0] M_DQT  = 8'hDB;
   localparam logic [7:0] M_COM  = 8'hFE;

   localparam logic [7:0] EXIF_TAG [4] = '{8'h45, 8'h78, 8'h69, 8'h66};

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  data;
      logic        typed;
      logic [2:0]  ev;
      logic [2:0]  err;
      logic [7:0]  marker;
      logic [15:0] len;
   } stim_row_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
   } req_word_type;

   localparam stim_row_type DIRECTED_ROWS [25] = '{
      '{CMD_DATA,    8'h00, 1'b1, EV_ERROR, ERR_BAD_START, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_END,     8'h00, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_UNUSED,  8'hA5, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_RESTART, 8'h5A, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_END,     8'hFF, 1'b1, EV_ERROR, ERR_BAD_START, 8'h00, 16'h0000},
      '{CMD_RESTART, 8'h00, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hD8, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hC0, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'h00, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'h08, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'h08, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'h00, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'h00, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'h03, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b0, EV_HEADER, ERR_NONE, 8'h00, 16'h0000},
      '{CMD_DATA,    8'hFF, 1'b1, EV_ERROR, ERR_PADDING, 8'hC0, 16'h0008}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = 8'h00;
   logic [1:0]            req_tuser   = CMD_DATA;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en   = 1'b0;
   logic                  csr_wr_data = 1'b0;

   // parser model state
   phase_type   ph;
   logic [2:0]  pad_cnt;
   logic [7:0]  cur_marker;
   logic [15:0] seg_len;
   logic [15:0] pay_idx;
   logic [5:0]  sect_cnt;
   logic [47:0] frame_bits;
   logic        exif_ok;
   logic        exif_en;

   rsp_item_type step_events [3];
   int           step_count;
   rsp_item_type expected_events [$];
   req_word_type pending [$];

   bit req_calm      = 1'b0;
   int rsp_hold      = 0;
   bit rsp_calm      = 1'b0;
   int rsp_calm_left = 0;
   int idle_cycles   = 0;

   int requests_sent   = 0;
   int items_counted   = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int event_tally [5] = '{0, 0, 0, 0, 0};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   jpeg_marker_segment_parser_top #(
      .SECTION_LIMIT(SECTION_LIMIT),
      .MAX_PADDING  (MAX_PADDING)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   task automatic clear_parse_state();
      ph         = PH_START_FF;
      pad_cnt    = '0;
      cur_marker = '0;
      seg_len    = '0;
      pay_idx    = '0;
      sect_cnt   = '0;
      frame_bits = '0;
      exif_ok    = 1'b1;
   endtask

   task automatic add_event(input logic [2:0] ev, input logic [2:0] err);
      rsp_item_type e;
      e                = '0;
      e.event_res      = ev;
      e.marker_code    = cur_marker;
      e.segment_length = seg_len;
      e.error_code     = err;
      if (ev == EV_FRAME) begin
         e.sample_precision = frame_bits[47:40];
         e.image_height     = frame_bits[39:24];
         e.image_width      = frame_bits[23:8];
         e.is_color         = (frame_bits[7:0] == COLOUR_COMPS);
      end
      step_events[step_count] = e;
      step_count++;
   endtask

   task automatic raise_error(input logic [2:0] err);
      ph = PH_DONE;
      add_event(EV_ERROR, err);
   endtask

   task automatic close_segment();
      bit counted;
      bit frame_marker;
      counted      = 1'b1;
      frame_marker = (cur_marker[7:4] == 4'hC) && (cur_marker != 8'hC4) &&
                     (cur_marker != 8'hC8) && (cur_marker != 8'hCC);
      if (cur_marker == M_SOS) begin
         sect_cnt = sect_cnt + 6'd1;
         ph       = PH_DONE;
         add_event(EV_DONE, ERR_NONE);
      end else if (cur_marker == M_EOI) begin
         raise_error(ERR_EOI);
      end else begin
         if (frame_marker) begin
            if (seg_len >= LEN_SOF_MIN) add_event(EV_FRAME, ERR_NONE);
         end else if (cur_marker == M_APP0) begin
            counted = 1'b0;
         end else if (cur_marker == M_APP1) begin
            if (exif_en && exif_ok && seg_len >= LEN_EXIF_MIN) add_event(EV_EXIF, ERR_NONE);
            else counted = 1'b0;
         end
         if (counted) sect_cnt = sect_cnt + 6'd1;
         if (int'(sect_cnt) >= SECTION_LIMIT - 1) begin
            ph = PH_DONE;
            add_event(EV_DONE, ERR_NONE);
         end else begin
            ph      = PH_MARKER;
            pad_cnt = '0;
         end
      end
   endtask

   // works out the results of one request and advances the model
   task automatic predict_parse_events(input logic [1:0] cmd, input logic [7:0] b);
      step_count = 0;
      case (cmd)
         CMD_DATA: begin
            case (ph)
               PH_START_FF: begin
                  if (b != BYTE_FF) raise_error(ERR_BAD_START);
                  else ph = PH_START_D8;
               end
               PH_START_D8: begin
                  if (b != M_SOI) begin
                     raise_error(ERR_BAD_START);
                  end else begin
                     ph      = PH_MARKER;
                     pad_cnt = '0;
                     if (int'(sect_cnt) >= SECTION_LIMIT - 1) begin
                        ph = PH_DONE;
                        add_event(EV_DONE, ERR_NONE);
                     end
                  end
               end
               PH_MARKER: begin
                  if (b == BYTE_FF) begin
                     if (int'(pad_cnt) >= MAX_PADDING) raise_error(ERR_PADDING);
                     else pad_cnt = pad_cnt + 3'd1;
                  end else begin
                     cur_marker = b;
                     ph         = PH_LEN_HI;
                  end
               end
               PH_LEN_HI: begin
                  seg_len = {b, 8'h00};
                  ph      = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  seg_len = {seg_len[15:8], b};
                  if (seg_len < LEN_MIN) begin
                     raise_error(ERR_BAD_LEN);
                  end else begin
                     add_event(EV_HEADER, ERR_NONE);
                     pay_idx    = '0;
                     exif_ok    = 1'b1;
                     frame_bits = '0;
                     if (seg_len == LEN_MIN) close_segment();
                     else ph = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  if (pay_idx < 16'd6) frame_bits[8 * (5 - int'(pay_idx)) +: 8] = b;
                  if (pay_idx < 16'd4 && b != EXIF_TAG[pay_idx[1:0]]) exif_ok = 1'b0;
                  pay_idx = pay_idx + 16'd1;
                  if (pay_idx >= seg_len - LEN_MIN) close_segment();
               end
               default: ;
            endcase
         end
         CMD_END: begin
            if (ph == PH_START_FF || ph == PH_START_D8) raise_error(ERR_BAD_START);
            else if (ph != PH_DONE) raise_error(ERR_TRUNC);
         end
         CMD_RESTART: clear_parse_state();
         default: ;
      endcase
      if (step_count > 0) step_events[step_count - 1].last_of_run = 1'b1;
   endtask

   task automatic send_request(input logic [1:0] cmd, input logic [7:0] b, input bit typed,
                               input rsp_item_type typed_item);
      int gap;
      bit passive;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      passive = (cmd == CMD_UNUSED) || (ph == PH_DONE && cmd != CMD_RESTART);
      if (!passive) items_counted++;
      predict_parse_events(cmd, b);
      if (typed) begin
         expected_events.push_back(typed_item);
      end else begin
         for (int i = 0; i < step_count; i++) expected_events.push_back(step_events[i]);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_exif_enable(input logic v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      exif_en = v;
   endtask

   task automatic queue_request(input logic [1:0] cmd, input logic [7:0] b);
      pending.push_back('{cmd, b});
   endtask

   task automatic queue_noise(input int n);
      repeat (n) queue_request(2'($urandom_range(0, 3)), 8'($urandom));
   endtask

   // one marker segment; forced < 0 lets the marker be picked at random
   task automatic queue_segment(input bit quick, input int forced, output bit stop);
      int          r;
      int          pads;
      int          full;
      int          sent;
      int          exif_style;
      int          corrupt_at;
      bit          colour;
      logic [7:0]  m;
      logic [7:0]  b;
      logic [15:0] len;
      stop = 1'b0;
      r    = $urandom_range(0, 39);
      pads = (r < 4) ? 0 : (r < 32) ? 1 : (r < 39) ? $urandom_range(2, MAX_PADDING) :
             MAX_PADDING + 1;
      repeat (pads) queue_request(CMD_DATA, BYTE_FF);
      if (forced >= 0) begin
         m = 8'(forced);
      end else if (quick) begin
         r = $urandom_range(0, 3);
         m = (r == 0) ? M_APP0 : (r == 1) ? M_DHT : M_DQT;
      end else begin
         case ($urandom_range(0, 11))
            0, 1:    m = M_SOF0 | 8'($urandom_range(0, 15));
            2, 3:    m = M_APP1;
            4:       m = M_APP0;
            5:       m = M_COM;
            6:       m = M_DQT;
            7:       m = M_DHT;
            8:       m = M_APP0 | 8'($urandom_range(0, 15));
            9:       m = M_SOS;
            default: m = 8'($urandom_range(0, 254));
         endcase
      end
      queue_request(CMD_DATA, m);
      r = $urandom_range(0, 59);
      if (r < 2) len = 16'($urandom_range(0, 1));
      else if (r < 5) len = 16'($urandom);
      else if (quick) len = 16'($urandom_range(2, 4));
      else if (m[7:4] == 4'hC)
         len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(2, 7)) : 16'($urandom_range(8, 12));
      else if (m == M_APP1)
         len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(2, 5)) : 16'($urandom_range(6, 12));
      else len = 16'($urandom_range(2, 8));
      queue_request(CMD_DATA, len[15:8]);
      queue_request(CMD_DATA, len[7:0]);
      if (len < LEN_MIN) begin
         stop = 1'b1;
      end else begin
         full = int'(len) - 2;
         sent = full;
         if (r >= 2 && r < 5) begin
            sent = $urandom_range(0, 5);
            if (sent > full) sent = full;
         end else if ($urandom_range(0, 24) == 0) begin
            sent = $urandom_range(0, full);
         end
         exif_style = $urandom_range(0, 3);
         corrupt_at = $urandom_range(0, 3);
         colour     = $urandom_range(0, 1);
         for (int i = 0; i < sent; i++) begin
            b = 8'($urandom);
            if (m == M_APP1 && exif_style != 0 && i < 4) begin
               b = EXIF_TAG[i];
               if (exif_style == 1 && i == corrupt_at) b = b ^ (8'h01 << $urandom_range(0, 7));
            end
            if (m[7:4] == 4'hC && colour && i == 5) b = COLOUR_COMPS;
            queue_request(CMD_DATA, b);
         end
         if (sent < full) begin
            queue_request(CMD_END, 8'($urandom));
            stop = 1'b1;
         end
      end
   endtask

   task automatic queue_jpeg_stream();
      int r;
      int segs;
      bit stop;
      req_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) queue_request(CMD_RESTART, 8'($urandom));
      r = $urandom_range(0, 19);
      if (r == 0) begin
         queue_request(CMD_DATA, 8'($urandom));
         queue_noise($urandom_range(0, 3));
      end else if (r == 1) begin
         queue_request(CMD_DATA, BYTE_FF);
         queue_request(CMD_DATA, 8'($urandom));
         queue_noise($urandom_range(0, 3));
      end else if (r == 2) begin
         if ($urandom_range(0, 1)) queue_request(CMD_DATA, BYTE_FF);
         queue_request(CMD_END, 8'($urandom));
      end else begin
         queue_request(CMD_DATA, BYTE_FF);
         queue_request(CMD_DATA, M_SOI);
         segs = ($urandom_range(0, 7) == 0) ?
                $urandom_range(SECTION_LIMIT - 2, SECTION_LIMIT + 2) : $urandom_range(0, 4);
         stop = 1'b0;
         for (int i = 0; i < segs && !stop; i++) queue_segment(segs > 6, -1, stop);
         if (!stop) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: queue_segment(1'b0, int'(M_SOS), stop);
               4, 5:       queue_segment(1'b0, int'(M_EOI), stop);
               6, 7:       queue_request(CMD_END, 8'($urandom));
               8:          queue_noise($urandom_range(1, 4));
               default:    ;
            endcase
         end
      end
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3)) queue_request(2'($urandom_range(0, 1)), 8'($urandom));
      end
   endtask

   // response side idling
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready    <= 1'b0;
         rsp_hold      <= 0;
         rsp_calm_left <= 0;
      end else begin
         if (rsp_calm_left == 0) begin
            rsp_calm      <= ($urandom_range(0, 3) == 0);
            rsp_calm_left <= $urandom_range(20, 120);
         end else begin
            rsp_calm_left <= rsp_calm_left - 1;
         end
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
            if (!rsp_calm && $urandom_range(0, 2) == 0) rsp_hold <= pick_gap();
         end
      end
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.event_res        = rsp_tuser;
         seen.marker_code      = rsp_tdata[7:0];
         seen.segment_length   = rsp_tdata[23:8];
         seen.sample_precision = rsp_tdata[31:24];
         seen.image_height     = rsp_tdata[47:32];
         seen.image_width      = rsp_tdata[63:48];
         seen.is_color         = rsp_tdata[64];
         seen.error_code       = rsp_tdata[67:65];
         seen.last_of_run      = rsp_tlast;
         results_checked++;
         if (seen.event_res < 3'd5) event_tally[seen.event_res]++;
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual event %0d marker %0h",
                     $time, seen.event_res, seen.marker_code);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            compare_field("event_res", 16'(want.event_res), 16'(seen.event_res));
            compare_field("marker_code", 16'(want.marker_code), 16'(seen.marker_code));
            compare_field("segment_length", want.segment_length, seen.segment_length);
            compare_field("sample_precision", 16'(want.sample_precision),
                          16'(seen.sample_precision));
            compare_field("image_height", want.image_height, seen.image_height);
            compare_field("image_width", want.image_width, seen.image_width);
            compare_field("is_color", 16'(want.is_color), 16'(seen.is_color));
            compare_field("error_code", 16'(want.error_code), 16'(seen.error_code));
            compare_field("last_of_run", 16'(want.last_of_run), 16'(seen.last_of_run));
            compare_field("tdata fill", 16'h0000, 16'(rsp_tdata[RSP_DATA_W-1:68]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_events.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type row;
      rsp_item_type typed_item;
      req_word_type word;
      int           target;
      clear_parse_state();
      exif_en = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         row                       = DIRECTED_ROWS[i];
         typed_item                = '0;
         typed_item.event_res      = row.ev;
         typed_item.error_code     = row.err;
         typed_item.marker_code    = row.marker;
         typed_item.segment_length = row.len;
         typed_item.last_of_run    = 1'b1;
         send_request(row.cmd, row.data, row.typed, typed_item);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_exif_enable(logic'(p % 2));
         target = requests_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (requests_sent < target) begin
            queue_jpeg_stream();
            while (pending.size() != 0) begin
               word = pending.pop_front();
               send_request(word.cmd, word.data, 1'b0, '0);
            end
         end
      end

      wait_idle();
      $display("summary: %0d requests (%0d acted upon), %0d results, %0d mismatches",
               requests_sent, items_counted, results_checked, mismatch_count);
      $display("summary: headers %0d, frames %0d, exif %0d, done %0d, errors %0d",
               event_tally[EV_HEADER], event_tally[EV_FRAME], event_tally[EV_EXIF],
               event_tally[EV_DONE], event_tally[EV_ERROR]);
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
